### rtl/assert_macros.svh
// Assertion helper macros for the s-expression parser RTL.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_PROP(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/sexpr_pkg.sv
// Shared types and constants for the s-expression tokenizer / tree builder.
// Used by sexpr_rec_fifo and sexpr_tokenizer_tree_builder; no dependencies.
package sexpr_pkg;

  localparam int DEF_MAX_DEPTH     = 16;
  localparam int DEF_MAX_ATOMS     = 4096;
  localparam int DEF_MAX_MSG_BYTES = 65536;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic REC_ATOM = 1'b0;
  localparam logic REC_END  = 1'b1;

  localparam logic [2:0] TY_LIST   = 3'd0;
  localparam logic [2:0] TY_SYMBOL = 3'd1;
  localparam logic [2:0] TY_STRING = 3'd2;
  localparam logic [2:0] TY_INT    = 3'd3;
  localparam logic [2:0] TY_FLOAT  = 3'd4;

  localparam logic [1:0] LK_NONE    = 2'd0;
  localparam logic [1:0] LK_CHILD   = 2'd1;
  localparam logic [1:0] LK_SIBLING = 2'd2;

  typedef struct packed {
    logic        rec_kind;
    logic [11:0] node_id;
    logic [2:0]  atom_type;
    logic [15:0] start_offset;
    logic [15:0] length;
    logic [1:0]  link_kind;
    logic [11:0] link_target;
    logic        error;
    logic        last;
  } rec_t;

endpackage

### rtl/sexpr_rec_fifo.sv
// Two-entry result queue between the parser core and the out_ channel.
// Depends on sexpr_pkg (rec_t) and assert_macros.svh.
`include "assert_macros.svh"

module sexpr_rec_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sexpr_pkg::rec_t    push_rec,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output sexpr_pkg::rec_t    out_rec
);
  import sexpr_pkg::*;

  rec_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign out_rec   = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_rec;
    end
  end

  `ASSERT_NEVER(a_no_overflow, push && full, "item pushed into full result queue")
  `ASSERT_PROP(a_cnt_bound, cnt_r <= 2'd2, "result queue count out of range")
  `ASSERT_PROP(a_full_holds, full && !pop |=> full, "full queue lost an item without pop")

endmodule

### rtl/sexpr_tokenizer_tree_builder.sv
// Top level: s-expression tokenizer and tree builder, one message byte per item.
// Depends on sexpr_pkg, sexpr_rec_fifo and assert_macros.svh.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_ch
//   out_    | output    | out_valid/out_stall| out_rec_kind .. out_last (one record)
//
// Ordinary bytes are taken one per cycle while in_stall is low.
// A ')' that closes a list is accepted, then its list record is issued.
// End of message: accept, one close per open list, end record (after an error, end record at accept).
// Results go through a 2-entry queue; in_stall rises while closes run or the queue is full.
// rst_n is synchronous; the level stack memory is not cleared.
`include "assert_macros.svh"

module sexpr_tokenizer_tree_builder #(
  parameter int MAX_DEPTH     = sexpr_pkg::DEF_MAX_DEPTH,
  parameter int MAX_ATOMS     = sexpr_pkg::DEF_MAX_ATOMS,
  parameter int MAX_MSG_BYTES = sexpr_pkg::DEF_MAX_MSG_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_rec_kind,
  output logic [11:0] out_node_id,
  output logic [2:0]  out_atom_type,
  output logic [15:0] out_start_offset,
  output logic [15:0] out_length,
  output logic [1:0]  out_link_kind,
  output logic [11:0] out_link_target,
  output logic        out_error,
  output logic        out_last
);
  import sexpr_pkg::*;

  localparam int IDXW = $clog2(MAX_ATOMS);
  localparam int CNTW = $clog2(MAX_ATOMS + 1);
  localparam int OFFW = $clog2(MAX_MSG_BYTES + 1);
  localparam int DPW  = $clog2(MAX_DEPTH + 1);
  localparam int AW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef struct packed {
    logic [IDXW-1:0] idx;
    logic [OFFW-1:0] start;
    logic            pv;
    logic [IDXW-1:0] pi;
  } level_t;

  typedef enum logic [1:0] {M_IDLE, M_SYM, M_STR} mode_t;
  typedef enum logic [1:0] {NC_UNSET, NC_NOTNUM, NC_INT, NC_FLOAT} nc_t;
  typedef enum logic [1:0] {P_NONE, P_CLOSE, P_UNWIND} pend_t;

  function automatic nc_t classify(input nc_t nc, input logic [7:0] c);
    logic digit;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (digit && nc == NC_UNSET) begin
      return NC_INT;
    end else if (c == CH_DOT && (nc == NC_UNSET || nc == NC_INT)) begin
      return NC_FLOAT;
    end else if (!digit) begin
      return NC_NOTNUM;
    end
    return nc;
  endfunction

  function automatic logic [2:0] sym_type(input nc_t nc);
    case (nc)
      NC_INT:   return TY_INT;
      NC_FLOAT: return TY_FLOAT;
      default:  return TY_SYMBOL;
    endcase
  endfunction

  function automatic rec_t mk_rec(input logic kind, input logic [IDXW-1:0] idx,
                                  input logic [2:0] ty, input logic [OFFW-1:0] st,
                                  input logic [OFFW-1:0] len, input logic [1:0] lk,
                                  input logic [IDXW-1:0] lt, input logic err,
                                  input logic lst);
    logic [31:0] i32;
    logic [31:0] s32;
    logic [31:0] l32;
    logic [31:0] t32;
    rec_t        r;
    i32 = 32'(idx);
    s32 = 32'(st);
    l32 = 32'(len);
    t32 = 32'(lt);
    r.rec_kind     = kind;
    r.node_id      = i32[11:0];
    r.atom_type    = ty;
    r.start_offset = s32[15:0];
    r.length       = l32[15:0];
    r.link_kind    = lk;
    r.link_target  = t32[11:0];
    r.error        = err;
    r.last         = lst;
    return r;
  endfunction

  // control state
  logic [DPW-1:0]  depth_r, depth_nxt;
  logic            root_pv_r, root_pv_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [OFFW-1:0] off_r, off_nxt;
  mode_t           mode_r, mode_nxt;
  nc_t             nc_r, nc_nxt;
  logic            esc_r, esc_nxt;
  logic            err_r, err_nxt;
  pend_t           pend_r, pend_nxt;
  logic            soft_clr;

  // payload state
  level_t          top_r, top_nxt;
  level_t          below_r;
  logic [IDXW-1:0] root_pi_r, root_pi_nxt;
  logic [IDXW-1:0] cur_atom_r, cur_atom_nxt;
  logic [OFFW-1:0] cur_start_r, cur_start_nxt;

  level_t          mem [MAX_DEPTH];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  logic [DPW-1:0]  dm1;
  logic [DPW-1:0]  dm2;

  logic            accept;
  logic            step;
  logic            fifo_full;
  logic            rec_en;
  rec_t            rec;
  rec_t            out_rec;

  logic [1:0]      cur_lk, pop_lk;
  logic [IDXW-1:0] cur_lt, pop_lt;

  assign in_stall = (pend_r != P_NONE) || fifo_full;
  assign accept   = in_valid && !in_stall;
  assign step     = (pend_r != P_NONE) && !fifo_full;

  assign dm1       = depth_r - DPW'(1);
  assign dm2       = depth_nxt - DPW'(2);
  assign mem_waddr = dm1[AW-1:0];
  assign mem_raddr = dm2[AW-1:0];

  // link of an atom finished at the current level
  always_comb begin
    if (depth_r != '0) begin
      cur_lk = top_r.pv ? LK_SIBLING : LK_CHILD;
      cur_lt = top_r.pv ? top_r.pi : top_r.idx;
    end else begin
      cur_lk = root_pv_r ? LK_SIBLING : LK_NONE;
      cur_lt = root_pv_r ? root_pi_r : '0;
    end
  end

  // link of the list closed by a pop
  always_comb begin
    if (depth_r > DPW'(1)) begin
      pop_lk = below_r.pv ? LK_SIBLING : LK_CHILD;
      pop_lt = below_r.pv ? below_r.pi : below_r.idx;
    end else begin
      pop_lk = root_pv_r ? LK_SIBLING : LK_NONE;
      pop_lt = root_pv_r ? root_pi_r : '0;
    end
  end

  always_comb begin
    depth_nxt     = depth_r;
    root_pv_nxt   = root_pv_r;
    root_pi_nxt   = root_pi_r;
    cnt_nxt       = cnt_r;
    off_nxt       = off_r;
    mode_nxt      = mode_r;
    nc_nxt        = nc_r;
    esc_nxt       = esc_r;
    err_nxt       = err_r;
    pend_nxt      = pend_r;
    top_nxt       = top_r;
    cur_atom_nxt  = cur_atom_r;
    cur_start_nxt = cur_start_r;
    soft_clr      = 1'b0;
    mem_we        = 1'b0;
    rec_en        = 1'b0;
    rec           = '0;

    if (step) begin
      if (depth_r != '0) begin
        rec_en    = 1'b1;
        rec       = mk_rec(REC_ATOM, top_r.idx, TY_LIST, top_r.start, '0,
                           pop_lk, pop_lt, 1'b0, pend_r == P_CLOSE);
        depth_nxt = depth_r - DPW'(1);
        if (depth_r > DPW'(1)) begin
          top_nxt    = below_r;
          top_nxt.pv = 1'b1;
          top_nxt.pi = top_r.idx;
        end else begin
          root_pv_nxt = 1'b1;
          root_pi_nxt = top_r.idx;
        end
        if (pend_r == P_CLOSE) begin
          pend_nxt = P_NONE;
        end
      end else begin
        rec_en   = 1'b1;
        rec      = mk_rec(REC_END, '0, TY_LIST, '0, '0, LK_NONE, '0, 1'b0, 1'b1);
        soft_clr = 1'b1;
      end
    end else if (accept) begin
      if (in_ch == CH_NUL) begin
        if (err_r) begin
          rec_en   = 1'b1;
          rec      = mk_rec(REC_END, '0, TY_LIST, '0, '0, LK_NONE, '0, 1'b1, 1'b1);
          soft_clr = 1'b1;
        end else begin
          if (mode_r == M_SYM || mode_r == M_STR) begin
            rec_en = 1'b1;
            rec    = mk_rec(REC_ATOM, cur_atom_r,
                            (mode_r == M_STR) ? TY_STRING : sym_type(nc_r),
                            cur_start_r, off_r - cur_start_r, cur_lk, cur_lt,
                            1'b0, 1'b0);
            if (depth_r != '0) begin
              top_nxt.pv = 1'b1;
              top_nxt.pi = cur_atom_r;
            end else begin
              root_pv_nxt = 1'b1;
              root_pi_nxt = cur_atom_r;
            end
          end
          mode_nxt = M_IDLE;
          pend_nxt = P_UNWIND;
        end
      end else if (!err_r) begin
        if (off_r >= OFFW'(MAX_MSG_BYTES)) begin
          err_nxt = 1'b1;
        end else begin
          off_nxt = off_r + OFFW'(1);
          case (mode_r)
            M_SYM: begin
              if (in_ch == CH_SPACE || in_ch == CH_RPAREN) begin
                rec_en   = 1'b1;
                rec      = mk_rec(REC_ATOM, cur_atom_r, sym_type(nc_r), cur_start_r,
                                  off_r - cur_start_r, cur_lk, cur_lt, 1'b0,
                                  !(in_ch == CH_RPAREN && depth_r != '0));
                mode_nxt = M_IDLE;
                if (depth_r != '0) begin
                  top_nxt.pv = 1'b1;
                  top_nxt.pi = cur_atom_r;
                  if (in_ch == CH_RPAREN) begin
                    pend_nxt = P_CLOSE;
                  end
                end else begin
                  root_pv_nxt = 1'b1;
                  root_pi_nxt = cur_atom_r;
                end
              end else begin
                nc_nxt = classify(nc_r, in_ch);
              end
            end
            M_STR: begin
              if (esc_r) begin
                esc_nxt = 1'b0;
              end else if (in_ch == CH_BSLASH) begin
                esc_nxt = 1'b1;
              end else if (in_ch == CH_QUOTE) begin
                rec_en   = 1'b1;
                rec      = mk_rec(REC_ATOM, cur_atom_r, TY_STRING, cur_start_r,
                                  off_r - cur_start_r, cur_lk, cur_lt, 1'b0, 1'b1);
                mode_nxt = M_IDLE;
                if (depth_r != '0) begin
                  top_nxt.pv = 1'b1;
                  top_nxt.pi = cur_atom_r;
                end else begin
                  root_pv_nxt = 1'b1;
                  root_pi_nxt = cur_atom_r;
                end
              end
            end
            default: begin
              if (in_ch == CH_SPACE) begin
                // nothing
              end else if (in_ch == CH_RPAREN) begin
                if (depth_r != '0) begin
                  pend_nxt = P_CLOSE;
                end
              end else if (cnt_r >= CNTW'(MAX_ATOMS) ||
                           (in_ch == CH_LPAREN && depth_r >= DPW'(MAX_DEPTH))) begin
                err_nxt = 1'b1;
              end else begin
                cnt_nxt = cnt_r + CNTW'(1);
                if (in_ch == CH_LPAREN) begin
                  mem_we        = (depth_r != '0);
                  top_nxt.idx   = cnt_r[IDXW-1:0];
                  top_nxt.start = off_r + OFFW'(1);
                  top_nxt.pv    = 1'b0;
                  top_nxt.pi    = '0;
                  depth_nxt     = depth_r + DPW'(1);
                end else if (in_ch == CH_QUOTE) begin
                  cur_atom_nxt  = cnt_r[IDXW-1:0];
                  cur_start_nxt = off_r + OFFW'(1);
                  esc_nxt       = 1'b0;
                  mode_nxt      = M_STR;
                end else begin
                  cur_atom_nxt  = cnt_r[IDXW-1:0];
                  cur_start_nxt = off_r;
                  nc_nxt        = classify(NC_UNSET, in_ch);
                  mode_nxt      = M_SYM;
                end
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || soft_clr) begin
      depth_r   <= '0;
      root_pv_r <= 1'b0;
      cnt_r     <= '0;
      off_r     <= '0;
      mode_r    <= M_IDLE;
      nc_r      <= NC_UNSET;
      esc_r     <= 1'b0;
      err_r     <= 1'b0;
      pend_r    <= P_NONE;
    end else begin
      depth_r   <= depth_nxt;
      root_pv_r <= root_pv_nxt;
      cnt_r     <= cnt_nxt;
      off_r     <= off_nxt;
      mode_r    <= mode_nxt;
      nc_r      <= nc_nxt;
      esc_r     <= esc_nxt;
      err_r     <= err_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r       <= top_nxt;
    root_pi_r   <= root_pi_nxt;
    cur_atom_r  <= cur_atom_nxt;
    cur_start_r <= cur_start_nxt;
  end

  // level stack below the top entry; below_r tracks entry depth-2
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= top_r;
    end
    if (mem_we && mem_waddr == mem_raddr) begin
      below_r <= top_r;
    end else begin
      below_r <= mem[mem_raddr];
    end
  end

  sexpr_rec_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_en),
    .push_rec  (rec),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rec   (out_rec)
  );

  assign out_rec_kind     = out_rec.rec_kind;
  assign out_node_id      = out_rec.node_id;
  assign out_atom_type    = out_rec.atom_type;
  assign out_start_offset = out_rec.start_offset;
  assign out_length       = out_rec.length;
  assign out_link_kind    = out_rec.link_kind;
  assign out_link_target  = out_rec.link_target;
  assign out_error        = out_rec.error;
  assign out_last         = out_rec.last;

  `ASSERT_PROP(a_depth_bound, depth_r <= DPW'(MAX_DEPTH), "level stack too deep")
  `ASSERT_PROP(a_end_last, out_valid && out_rec_kind == REC_END |-> out_last, "end not last")
  `ASSERT_PROP(a_atom_noerr, out_valid && out_rec_kind == REC_ATOM |-> !out_error, "atom error")
  `ASSERT_PROP(a_eom_unwind, accept && in_ch == CH_NUL && !err_r |=> pend_r == P_UNWIND, "unwind")

endmodule
